### hw/rtl/e2g_pkg.sv
// types, constants and constant tables for the ecef to geodetic converter
`timescale 1ns / 1ps
package e2g_pkg;

  localparam int NIT   = 60;
  localparam int CIT_W = 6;

  typedef logic signed [63:0] s64_t;
  typedef logic [63:0]        u64_t;
  typedef s64_t               atn_tab_t [NIT];

  localparam s64_t ONE_Q62  = 64'sh4000_0000_0000_0000;
  localparam s64_t HALF_PI  = 64'sh2000_0000_0000_0000;
  localparam s64_t S64_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam u64_t PI_Q61   = 64'h6487_ED51_10B4_611A;
  localparam u64_t AXIS_PZ  = 64'd6378136000;
  localparam u64_t AXIS_WGS = 64'd6378137000;
  localparam u64_t DEN_PZ   = 64'd298257839303;
  localparam u64_t DEN_WGS  = 64'd298257223563;

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_ELLIPSOID  = 2'd0;
  localparam cfg_idx_t CFG_ITER_LIMIT = 2'd1;
  localparam cfg_idx_t CFG_TOLERANCE  = 2'd2;

  typedef logic [1:0] stat_t;
  localparam stat_t STAT_CONV  = 2'd0;
  localparam stat_t STAT_POLAR = 2'd1;
  localparam stat_t STAT_LIMIT = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE, S_N0, S_N1, S_N2, S_N3,
    S_L0, S_L1, S_L2, S_L3, S_L4, S_L5, S_L6, S_L7, S_L8,
    S_F4, S_F5, S_F6, S_F7, S_F8,
    S_P1, S_P2, S_P3,
    S_IS1, S_IS2, S_IS3, S_IS4,
    S_MUL, S_MULF, S_COR, S_OUT
  } state_t;

  function automatic u64_t abs64(input s64_t a);
    u64_t r;
    r = a[63] ? u64_t'(-a) : u64_t'(a);
    return r;
  endfunction

  function automatic u64_t uquot_f(input u64_t n, input u64_t d);
    u64_t q;
    logic [64:0] rem;
    q   = '0;
    rem = '0;
    for (int k = 63; k >= 0; k--) begin
      rem = {rem[63:0], n[k]};
      if (rem >= {1'b0, d}) begin
        rem  = rem - {1'b0, d};
        q[k] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic u64_t divfrac_f(input u64_t num, input u64_t den, input int bits);
    u64_t q;
    u64_t n;
    q = '0;
    n = num;
    if (den == 64'd0 || num >= den || den[63]) return '0;
    for (int k = 0; k < bits; k++) begin
      n = n << 1;
      q = q << 1;
      if (n >= den) begin
        n    = n - den;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic s64_t fmul_f(input s64_t a, input s64_t b, input int sh);
    logic [127:0] p;
    u64_t m;
    p = {64'd0, abs64(a)} * {64'd0, abs64(b)};
    p = p + (128'd1 << (sh - 1));
    p = p >> sh;
    m = (p[127:63] != '0) ? u64_t'(S64_MAX) : p[63:0];
    return (a[63] != b[63]) ? -s64_t'(m) : s64_t'(m);
  endfunction

  function automatic s64_t inv_sqrt_f(input s64_t w);
    s64_t r;
    r = ONE_Q62;
    for (int k = 0; k < 8; k++)
      r = r + fmul_f(r, ONE_Q62 - fmul_f(w, fmul_f(r, r, 62), 62), 63);
    return r;
  endfunction

  function automatic atn_tab_t atn_gen();
    atn_tab_t t;
    u64_t sum;
    u64_t term;
    t[0] = 64'sd1 <<< 60;
    for (int i = 1; i < NIT; i++) begin
      sum = '0;
      for (int k = 0; i * (2 * k + 1) <= 61; k++) begin
        term = uquot_f(64'd1 << (61 - i * (2 * k + 1)), u64_t'(2 * k + 1));
        sum  = k[0] ? sum - term : sum + term;
      end
      t[i] = s64_t'(divfrac_f(sum, PI_Q61, 62));
    end
    return t;
  endfunction

  function automatic s64_t inv_gain_f();
    s64_t p;
    p = 64'sd1 <<< 60;
    for (int i = 0; i < NIT && 2 * i <= 62; i++)
      p = p + (p >>> (2 * i));
    return inv_sqrt_f(p) >>> 1;
  endfunction

  function automatic s64_t ecc2_f(input u64_t den);
    s64_t f;
    f = s64_t'(divfrac_f(64'd1000000000, den, 62));
    return (f <<< 1) - fmul_f(f, f, 62);
  endfunction

  localparam atn_tab_t ATN      = atn_gen();
  localparam s64_t     INV_GAIN = inv_gain_f();
  localparam s64_t     ECC2_PZ  = ecc2_f(DEN_PZ);
  localparam s64_t     ECC2_WGS = ecc2_f(DEN_WGS);

endpackage

### hw/rtl/ecef_to_geodetic_top.sv
// ecef to geodetic converter: sequencer, shared multiplier and shared cordic unit
// run time: the polar axis skips the latitude loop; otherwise it grows with the number of
//   latitude passes (at most iteration_limit + 1) and is set by the 60-step cordic
//   and the 32x32 multiplier shared by all products
// one item at a time: start is taken only when idle; busy is high from accept until the result beat
// the result beat is shown for one cycle on out_valid; the receiver cannot stall
// synchronous active-low reset clears the sequencer and loads register defaults
`timescale 1ns / 1ps
module ecef_to_geodetic_top
  import e2g_pkg::*;
#(
  parameter int ANGLE_BITS = 32,
  parameter int COORD_BITS = 37
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] in_pos_x,
  input  logic signed [COORD_BITS-1:0] in_pos_y,
  input  logic signed [COORD_BITS-1:0] in_pos_z,
  output logic                         out_valid,
  output logic signed [ANGLE_BITS-1:0] out_latitude,
  output logic signed [ANGLE_BITS-1:0] out_longitude,
  output logic signed [COORD_BITS-1:0] out_height,
  output logic [1:0]                   out_status,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [1:0]                   cfg_index,
  input  logic [9:0]                   cfg_data
);

  localparam int   CFRAC  = 61 - COORD_BITS;
  localparam int   ASH    = 63 - ANGLE_BITS;
  localparam s64_t AS_PZ  = s64_t'(AXIS_PZ << CFRAC);
  localparam s64_t AS_WGS = s64_t'(AXIS_WGS << CFRAC);
  localparam s64_t HMAX   = (64'sd1 <<< (COORD_BITS - 1)) - 64'sd1;
  localparam s64_t HMIN   = -HMAX - 64'sd1;
  localparam s64_t ARND   = 64'sd1 <<< (ASH - 1);
  localparam s64_t HRND   = 64'sd1 <<< (CFRAC - 1);

  state_t state_r, state_nxt, ret_r, ret_nxt, isr_r, isr_nxt;

  logic       ell_r;
  logic [7:0] lim_r;
  logic [9:0] tol_r;

  s64_t x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  s64_t rho_r, rho_nxt, b0_r, b0_nxt, lat_r, lat_nxt, lon_r, lon_nxt;
  s64_t s_r, s_nxt, c_r, c_nxt, w_r, w_nxt, r_r, r_nxt, t_r, t_nxt, h_r, h_nxt;
  stat_t st_r, st_nxt;
  logic [7:0] cnt_r, cnt_nxt;
  logic       fin_r, fin_nxt;
  logic [2:0] isk_r, isk_nxt;

  u64_t         ua_r, ua_nxt, ub_r, ub_nxt;
  logic         mneg_r, mneg_nxt, msh63_r, msh63_nxt;
  logic [127:0] acc_r, acc_nxt;
  logic [1:0]   mcnt_r, mcnt_nxt;

  s64_t             cx_r, cx_nxt, cy_r, cy_nxt, cz_r, cz_nxt;
  logic             crot_r, crot_nxt;
  logic [CIT_W-1:0] cit_r, cit_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [ANGLE_BITS-1:0] out_lat_r, out_lat_nxt, out_lon_r, out_lon_nxt;
  logic [COORD_BITS-1:0] out_h_r, out_h_nxt;
  stat_t                 out_st_r, out_st_nxt;

  logic   mul_go, mul_sh63, cor_go, cor_rot;
  s64_t   mul_a, mul_b, cor_x, cor_y, cor_z;
  state_t call_ret;

  s64_t e2, a_s, tol, dlt, dabs;
  s64_t lat_v, lon_v, hv, hq;

  logic [31:0]  mop_a, mop_b;
  logic [63:0]  pp;
  logic [6:0]   psh;
  logic [127:0] mq;
  u64_t         mmag;
  s64_t         mres;

  s64_t xs, ys, at, cx_n, cy_n, cz_n;
  logic cpos;

  assign e2  = ell_r ? ECC2_WGS : ECC2_PZ;
  assign a_s = ell_r ? AS_WGS : AS_PZ;
  assign tol = s64_t'({54'd0, tol_r} << ASH);
  assign dlt  = cz_r - b0_r;
  assign dabs = dlt[63] ? -dlt : dlt;

  // multiplier: one 32x32 partial product per cycle
  assign mop_a = mcnt_r[0] ? ua_r[63:32] : ua_r[31:0];
  assign mop_b = mcnt_r[1] ? ub_r[63:32] : ub_r[31:0];
  assign pp    = 64'(mop_a) * 64'(mop_b);
  assign psh   = {(mcnt_r[0] & mcnt_r[1]), (mcnt_r[0] ^ mcnt_r[1]), 5'd0};
  assign mq    = msh63_r ? (acc_r >> 63) : (acc_r >> 62);
  assign mmag  = (mq[127:63] != '0) ? u64_t'(S64_MAX) : mq[63:0];
  assign mres  = mneg_r ? -s64_t'(mmag) : s64_t'(mmag);

  // cordic micro-rotation
  assign xs   = cx_r >>> cit_r;
  assign ys   = cy_r >>> cit_r;
  assign at   = ATN[cit_r];
  assign cpos = crot_r ? cz_r[63] : ~cy_r[63];
  assign cx_n = cpos ? cx_r + ys : cx_r - ys;
  assign cy_n = cpos ? cy_r - xs : cy_r + xs;
  assign cz_n = cpos ? cz_r + at : cz_r - at;

  assign lat_v = (lat_r + ARND) >>> ASH;
  assign lon_v = (lon_r + ARND) >>> ASH;
  assign hv    = (h_r + HRND) >>> CFRAC;
  assign hq    = (hv > HMAX) ? HMAX : ((hv < HMIN) ? HMIN : hv);

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    isr_nxt   = isr_r;
    x_nxt = x_r; y_nxt = y_r; z_nxt = z_r;
    rho_nxt = rho_r; b0_nxt = b0_r; lat_nxt = lat_r; lon_nxt = lon_r;
    s_nxt = s_r; c_nxt = c_r; w_nxt = w_r; r_nxt = r_r; t_nxt = t_r; h_nxt = h_r;
    st_nxt = st_r; cnt_nxt = cnt_r; fin_nxt = fin_r; isk_nxt = isk_r;
    ua_nxt = ua_r; ub_nxt = ub_r; mneg_nxt = mneg_r; msh63_nxt = msh63_r;
    acc_nxt = acc_r; mcnt_nxt = mcnt_r;
    cx_nxt = cx_r; cy_nxt = cy_r; cz_nxt = cz_r; crot_nxt = crot_r; cit_nxt = cit_r;
    out_valid_nxt = 1'b0;
    out_lat_nxt = out_lat_r; out_lon_nxt = out_lon_r;
    out_h_nxt = out_h_r; out_st_nxt = out_st_r;
    mul_go = 1'b0; mul_a = '0; mul_b = '0; mul_sh63 = 1'b0;
    cor_go = 1'b0; cor_x = '0; cor_y = '0; cor_z = '0; cor_rot = 1'b0;
    call_ret = S_IDLE;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          x_nxt = s64_t'(in_pos_x) <<< CFRAC;
          y_nxt = s64_t'(in_pos_y) <<< CFRAC;
          z_nxt = s64_t'(in_pos_z) <<< CFRAC;
          if (in_pos_x == '0 && in_pos_y == '0) begin
            lat_nxt   = (in_pos_z > 0) ? HALF_PI : -HALF_PI;
            lon_nxt   = '0;
            st_nxt    = STAT_POLAR;
            w_nxt     = ONE_Q62 - e2;
            r_nxt     = ONE_Q62;
            isk_nxt   = '0;
            isr_nxt   = S_P1;
            state_nxt = S_IS1;
          end else begin
            st_nxt    = STAT_CONV;
            cnt_nxt   = '0;
            fin_nxt   = 1'b0;
            state_nxt = S_N0;
          end
        end
      end
      S_N0: begin
        cor_go = 1'b1;
        cor_x  = x_r[63] ? -x_r : x_r;
        cor_y  = x_r[63] ? -y_r : y_r;
        call_ret = S_N1;
      end
      S_N1: begin
        lon_nxt  = x_r[63] ? cz_r + (y_r[63] ? -ONE_Q62 : ONE_Q62) : cz_r;
        mul_go   = 1'b1; mul_a = cx_r; mul_b = INV_GAIN;
        call_ret = S_N2;
      end
      S_N2: begin
        rho_nxt  = t_r;
        cor_go   = 1'b1; cor_x = t_r; cor_y = z_r;
        call_ret = S_N3;
      end
      S_N3: begin
        b0_nxt    = cz_r;
        state_nxt = S_L0;
      end
      S_L0: begin
        cor_go = 1'b1; cor_rot = 1'b1; cor_x = INV_GAIN; cor_z = b0_r;
        call_ret = S_L1;
      end
      S_L1: begin
        s_nxt    = cy_r;
        c_nxt    = cx_r;
        mul_go   = 1'b1; mul_a = cy_r; mul_b = cy_r;
        call_ret = S_L2;
      end
      S_L2: begin
        mul_go = 1'b1; mul_a = e2; mul_b = t_r;
        call_ret = S_L3;
      end
      S_L3: begin
        w_nxt     = ONE_Q62 - t_r;
        r_nxt     = ONE_Q62;
        isk_nxt   = '0;
        isr_nxt   = fin_r ? S_F4 : S_L4;
        state_nxt = S_IS1;
      end
      S_L4: begin
        mul_go = 1'b1; mul_a = a_s; mul_b = r_r;
        call_ret = S_L5;
      end
      S_L5: begin
        mul_go = 1'b1; mul_a = e2; mul_b = t_r;
        call_ret = S_L6;
      end
      S_L6: begin
        mul_go = 1'b1; mul_a = t_r; mul_b = s_r;
        call_ret = S_L7;
      end
      S_L7: begin
        cor_go = 1'b1; cor_x = rho_r; cor_y = z_r + t_r;
        call_ret = S_L8;
      end
      S_L8: begin
        b0_nxt    = cz_r;
        state_nxt = S_L0;
        if (dabs < tol) begin
          fin_nxt = 1'b1;
          lat_nxt = cz_r;
        end else if (cnt_r >= lim_r) begin
          st_nxt  = STAT_LIMIT;
          fin_nxt = 1'b1;
          lat_nxt = cz_r;
        end else begin
          cnt_nxt = cnt_r + 8'd1;
        end
      end
      S_F4: begin
        mul_go = 1'b1; mul_a = w_r; mul_b = r_r;
        call_ret = S_F5;
      end
      S_F5: begin
        mul_go = 1'b1; mul_a = a_s; mul_b = t_r;
        call_ret = S_F6;
      end
      S_F6: begin
        h_nxt  = -t_r;
        mul_go = 1'b1; mul_a = rho_r; mul_b = c_r;
        call_ret = S_F7;
      end
      S_F7: begin
        h_nxt  = h_r + t_r;
        mul_go = 1'b1; mul_a = z_r; mul_b = s_r;
        call_ret = S_F8;
      end
      S_F8: begin
        h_nxt     = h_r + t_r;
        state_nxt = S_OUT;
      end
      S_P1: begin
        mul_go = 1'b1; mul_a = w_r; mul_b = r_r;
        call_ret = S_P2;
      end
      S_P2: begin
        mul_go = 1'b1; mul_a = a_s; mul_b = t_r;
        call_ret = S_P3;
      end
      S_P3: begin
        h_nxt     = (z_r[63] ? -z_r : z_r) - t_r;
        state_nxt = S_OUT;
      end
      S_IS1: begin
        mul_go = 1'b1; mul_a = r_r; mul_b = r_r;
        call_ret = S_IS2;
      end
      S_IS2: begin
        mul_go = 1'b1; mul_a = w_r; mul_b = t_r;
        call_ret = S_IS3;
      end
      S_IS3: begin
        mul_go = 1'b1; mul_a = r_r; mul_b = ONE_Q62 - t_r; mul_sh63 = 1'b1;
        call_ret = S_IS4;
      end
      S_IS4: begin
        r_nxt     = r_r + t_r;
        isk_nxt   = isk_r + 3'd1;
        state_nxt = (isk_r == 3'd7) ? isr_r : S_IS1;
      end
      S_MUL: begin
        acc_nxt  = acc_r + (128'(pp) << psh);
        mcnt_nxt = mcnt_r + 2'd1;
        if (mcnt_r == 2'd3) state_nxt = S_MULF;
      end
      S_MULF: begin
        t_nxt     = mres;
        state_nxt = ret_r;
      end
      S_COR: begin
        cx_nxt  = cx_n;
        cy_nxt  = cy_n;
        cz_nxt  = cz_n;
        cit_nxt = cit_r + 1'b1;
        if (cit_r == CIT_W'(NIT - 1)) state_nxt = ret_r;
      end
      S_OUT: begin
        out_valid_nxt = 1'b1;
        out_lat_nxt   = lat_v[ANGLE_BITS-1:0];
        out_lon_nxt   = lon_v[ANGLE_BITS-1:0];
        out_h_nxt     = hq[COORD_BITS-1:0];
        out_st_nxt    = st_r;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    if (mul_go) begin
      ua_nxt    = abs64(mul_a);
      ub_nxt    = abs64(mul_b);
      mneg_nxt  = mul_a[63] ^ mul_b[63];
      msh63_nxt = mul_sh63;
      acc_nxt   = mul_sh63 ? (128'd1 << 62) : (128'd1 << 61);
      mcnt_nxt  = '0;
      ret_nxt   = call_ret;
      state_nxt = S_MUL;
    end
    if (cor_go) begin
      cx_nxt    = cor_x;
      cy_nxt    = cor_y;
      cz_nxt    = cor_z;
      crot_nxt  = cor_rot;
      cit_nxt   = '0;
      ret_nxt   = call_ret;
      state_nxt = S_COR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      ell_r       <= 1'b1;
      lim_r       <= 8'd100;
      tol_r       <= 10'd1;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_ELLIPSOID:  ell_r <= cfg_data[0];
          CFG_ITER_LIMIT: lim_r <= cfg_data[7:0];
          CFG_TOLERANCE:  tol_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    ret_r <= ret_nxt; isr_r <= isr_nxt;
    x_r <= x_nxt; y_r <= y_nxt; z_r <= z_nxt;
    rho_r <= rho_nxt; b0_r <= b0_nxt; lat_r <= lat_nxt; lon_r <= lon_nxt;
    s_r <= s_nxt; c_r <= c_nxt; w_r <= w_nxt; r_r <= r_nxt; t_r <= t_nxt; h_r <= h_nxt;
    st_r <= st_nxt; cnt_r <= cnt_nxt; fin_r <= fin_nxt; isk_r <= isk_nxt;
    ua_r <= ua_nxt; ub_r <= ub_nxt; mneg_r <= mneg_nxt; msh63_r <= msh63_nxt;
    acc_r <= acc_nxt; mcnt_r <= mcnt_nxt;
    cx_r <= cx_nxt; cy_r <= cy_nxt; cz_r <= cz_nxt; crot_r <= crot_nxt; cit_r <= cit_nxt;
    out_lat_r <= out_lat_nxt; out_lon_r <= out_lon_nxt;
    out_h_r <= out_h_nxt; out_st_r <= out_st_nxt;
  end

  assign busy          = (state_r != S_IDLE);
  assign cfg_ready     = 1'b1;
  assign out_valid     = out_valid_r;
  assign out_latitude  = out_lat_r;
  assign out_longitude = out_lon_r;
  assign out_height    = out_h_r;
  assign out_status    = out_st_r;

endmodule
